FILE: rtl/core/texel_screen_region_select_unit_assert.svh
// Assertion macros used by the checker file.
// Each macro samples on the rising clock and is disabled during reset.
`ifndef TEXEL_SCREEN_REGION_SELECT_UNIT_ASSERT_SVH
`define TEXEL_SCREEN_REGION_SELECT_UNIT_ASSERT_SVH

// Same-cycle implication
`define TSRS_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("response check failed");

// Next-cycle implication
`define TSRS_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("response check failed");

`endif

FILE: rtl/core/tsrs_pkg.sv
`default_nettype none
package tsrs_pkg;

   localparam int MAX_VERTICES = 32;
   localparam int VTX_AW       = $clog2(MAX_VERTICES);
   localparam int CLIP_W       = 50;
   localparam int DIV_W        = 52;
   localparam int QUO_W        = 33;

   localparam logic [15:0] WIDTH_RESET  = 16'd1920;
   localparam logic [15:0] HEIGHT_RESET = 16'd1080;
   localparam logic [5:0]  COUNT_RESET  = 6'd4;

   // Request kinds
   typedef enum logic [1:0] {
      ACT_LOAD_COEF   = 2'd0,
      ACT_LOAD_VERTEX = 2'd1,
      ACT_TEST        = 2'd2
   } action_type;

   // Register indexes
   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_COUNT  = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MREAD, ST_MMUL, ST_MACC, ST_CLIP, ST_DINIT, ST_DSTEP,
      ST_SCALE, ST_SAT, ST_VFIRST, ST_VLATCH, ST_EREAD, ST_EDIFF, ST_EMUL,
      ST_EDEC, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_START, OP_COEF_RD, OP_MUL, OP_ACC, OP_CLIP, OP_DIV_INIT,
      OP_DIV_STEP, OP_SCALE, OP_SAT, OP_VTX_RD, OP_VTX_LATCH, OP_EDGE_DIFF,
      OP_EDGE_MUL, OP_EDGE_DEC, OP_EMIT
   } op_type;

   typedef struct packed {
      logic              req_ready;
      op_type            op;
      logic              pass;
      logic [1:0]        row;
      logic [1:0]        col;
      logic              axis;
      logic [VTX_AW-1:0] vtx_addr;
   } cmd_type;

   typedef struct packed {
      logic              vis;
      logic              on_edge;
      logic              n_zero;
      logic [VTX_AW-1:0] n_last;
      logic              rsp_free;
   } status_type;

endpackage
`default_nettype wire

FILE: rtl/core/tsrs_ctrl.sv
`default_nettype none
module tsrs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic [1:0]           req_action,
   input  wire tsrs_pkg::status_type status,
   output tsrs_pkg::cmd_type         cmd
);

   tsrs_pkg::state_type state_ff, state_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic                pass_ff, pass_in;
   logic                axis_ff, axis_in;

   // Hold sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsrs_pkg::ST_IDLE;
         cnt_ff   <= '0;
         pass_ff  <= 1'b0;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pass_ff  <= pass_in;
         axis_ff  <= axis_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pass_in  = pass_ff;
      axis_in  = axis_ff;
      case (state_ff)
         tsrs_pkg::ST_IDLE: begin
            if (req_tvalid && req_action == tsrs_pkg::ACT_TEST) begin
               state_in = tsrs_pkg::ST_MREAD;
               cnt_in   = '0;
               pass_in  = 1'b0;
            end
         end
         tsrs_pkg::ST_MREAD: state_in = tsrs_pkg::ST_MMUL;
         tsrs_pkg::ST_MMUL:  state_in = tsrs_pkg::ST_MACC;
         tsrs_pkg::ST_MACC: begin
            if (cnt_ff[3:0] == 4'hF) begin
               cnt_in = '0;
               if (!pass_ff) begin
                  pass_in  = 1'b1;
                  state_in = tsrs_pkg::ST_MREAD;
               end else begin
                  state_in = tsrs_pkg::ST_CLIP;
               end
            end else begin
               cnt_in   = cnt_ff + 5'd1;
               state_in = tsrs_pkg::ST_MREAD;
            end
         end
         tsrs_pkg::ST_CLIP: begin
            axis_in  = 1'b0;
            state_in = status.vis ? tsrs_pkg::ST_DINIT : tsrs_pkg::ST_DONE;
         end
         tsrs_pkg::ST_DINIT: begin
            cnt_in   = '0;
            state_in = tsrs_pkg::ST_DSTEP;
         end
         tsrs_pkg::ST_DSTEP: begin
            if (cnt_ff == 5'd31) state_in = tsrs_pkg::ST_SCALE;
            else cnt_in = cnt_ff + 5'd1;
         end
         tsrs_pkg::ST_SCALE: state_in = tsrs_pkg::ST_SAT;
         tsrs_pkg::ST_SAT: begin
            if (!axis_ff) begin
               axis_in  = 1'b1;
               state_in = tsrs_pkg::ST_DINIT;
            end else begin
               state_in = status.n_zero ? tsrs_pkg::ST_DONE : tsrs_pkg::ST_VFIRST;
            end
         end
         tsrs_pkg::ST_VFIRST: state_in = tsrs_pkg::ST_VLATCH;
         tsrs_pkg::ST_VLATCH: begin
            cnt_in   = '0;
            state_in = tsrs_pkg::ST_EREAD;
         end
         tsrs_pkg::ST_EREAD: state_in = tsrs_pkg::ST_EDIFF;
         tsrs_pkg::ST_EDIFF: state_in = tsrs_pkg::ST_EMUL;
         tsrs_pkg::ST_EMUL:  state_in = tsrs_pkg::ST_EDEC;
         tsrs_pkg::ST_EDEC: begin
            if (status.on_edge || cnt_ff[tsrs_pkg::VTX_AW-1:0] == status.n_last) begin
               state_in = tsrs_pkg::ST_DONE;
            end else begin
               cnt_in   = cnt_ff + 5'd1;
               state_in = tsrs_pkg::ST_EREAD;
            end
         end
         tsrs_pkg::ST_DONE: begin
            if (status.rsp_free) state_in = tsrs_pkg::ST_IDLE;
         end
         default: state_in = tsrs_pkg::ST_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd           = '0;
      cmd.op        = tsrs_pkg::OP_NONE;
      cmd.pass      = pass_ff;
      cmd.row       = cnt_ff[3:2];
      cmd.col       = cnt_ff[1:0];
      cmd.axis      = axis_ff;
      cmd.vtx_addr  = cnt_ff[tsrs_pkg::VTX_AW-1:0];
      case (state_ff)
         tsrs_pkg::ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (req_tvalid && req_action == tsrs_pkg::ACT_TEST) cmd.op = tsrs_pkg::OP_START;
         end
         tsrs_pkg::ST_MREAD:  cmd.op = tsrs_pkg::OP_COEF_RD;
         tsrs_pkg::ST_MMUL:   cmd.op = tsrs_pkg::OP_MUL;
         tsrs_pkg::ST_MACC:   cmd.op = tsrs_pkg::OP_ACC;
         tsrs_pkg::ST_CLIP:   cmd.op = tsrs_pkg::OP_CLIP;
         tsrs_pkg::ST_DINIT:  cmd.op = tsrs_pkg::OP_DIV_INIT;
         tsrs_pkg::ST_DSTEP:  cmd.op = tsrs_pkg::OP_DIV_STEP;
         tsrs_pkg::ST_SCALE:  cmd.op = tsrs_pkg::OP_SCALE;
         tsrs_pkg::ST_SAT:    cmd.op = tsrs_pkg::OP_SAT;
         tsrs_pkg::ST_VFIRST: begin
            cmd.op       = tsrs_pkg::OP_VTX_RD;
            cmd.vtx_addr = status.n_last;
         end
         tsrs_pkg::ST_VLATCH: cmd.op = tsrs_pkg::OP_VTX_LATCH;
         tsrs_pkg::ST_EREAD:  cmd.op = tsrs_pkg::OP_VTX_RD;
         tsrs_pkg::ST_EDIFF:  cmd.op = tsrs_pkg::OP_EDGE_DIFF;
         tsrs_pkg::ST_EMUL:   cmd.op = tsrs_pkg::OP_EDGE_MUL;
         tsrs_pkg::ST_EDEC:   cmd.op = tsrs_pkg::OP_EDGE_DEC;
         tsrs_pkg::ST_DONE: begin
            if (status.rsp_free) cmd.op = tsrs_pkg::OP_EMIT;
         end
         default: cmd.op = tsrs_pkg::OP_NONE;
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/core/tsrs_dpath.sv
`default_nettype none
module tsrs_dpath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic [2:0]           req_tuser,
   input  wire logic [199:0]         req_tdata,
   input  wire logic                 csr_valid,
   input  wire logic [1:0]           csr_index,
   input  wire logic [31:0]          csr_data,
   input  wire tsrs_pkg::cmd_type    cmd,
   output tsrs_pkg::status_type      status,
   input  wire logic                 rsp_tready,
   output logic                      rsp_tvalid,
   output logic [71:0]               rsp_tdata
);

   localparam int CW = tsrs_pkg::CLIP_W;
   localparam int DW = tsrs_pkg::DIV_W;
   localparam int QW = tsrs_pkg::QUO_W;
   localparam int AW = tsrs_pkg::VTX_AW;

   // Request fields
   logic        [1:0]  f_action;
   logic               f_msel;
   logic        [4:0]  f_slot;
   logic signed [31:0] f_coef, f_vx, f_vy, f_px, f_py, f_pz;
   logic               f_cand;
   logic               req_accept;

   assign f_action   = req_tuser[1:0];
   assign f_msel     = req_tuser[2];
   assign f_slot     = req_tdata[4:0];
   assign f_coef     = req_tdata[36:5];
   assign f_vx       = req_tdata[68:37];
   assign f_vy       = req_tdata[100:69];
   assign f_px       = req_tdata[132:101];
   assign f_py       = req_tdata[164:133];
   assign f_pz       = req_tdata[196:165];
   assign f_cand     = req_tdata[197];
   assign req_accept = req_tvalid & cmd.req_ready;

   // Configuration registers
   logic [15:0] width_ff, height_ff;
   logic [5:0]  count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= tsrs_pkg::WIDTH_RESET;
         height_ff <= tsrs_pkg::HEIGHT_RESET;
         count_ff  <= tsrs_pkg::COUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            tsrs_pkg::CSR_WIDTH:  width_ff  <= csr_data[15:0];
            tsrs_pkg::CSR_HEIGHT: height_ff <= csr_data[15:0];
            tsrs_pkg::CSR_COUNT:  count_ff  <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // Coefficient and vertex stores
   logic signed [31:0] view_mem [16];
   logic signed [31:0] proj_mem [16];
   logic signed [31:0] vx_mem [tsrs_pkg::MAX_VERTICES];
   logic signed [31:0] vy_mem [tsrs_pkg::MAX_VERTICES];
   logic signed [31:0] coef_rd_ff, vx_rd_ff, vy_rd_ff;
   logic        [3:0]  coef_addr;
   logic               coef_we, vtx_we;

   assign coef_addr = {cmd.col, cmd.row};
   assign coef_we   = req_accept && f_action == tsrs_pkg::ACT_LOAD_COEF && !f_slot[4];
   assign vtx_we    = req_accept && f_action == tsrs_pkg::ACT_LOAD_VERTEX &&
                      32'(f_slot) < tsrs_pkg::MAX_VERTICES;

   always_ff @(posedge clock) begin
      if (coef_we && !f_msel) view_mem[f_slot[3:0]] <= f_coef;
      if (coef_we && f_msel)  proj_mem[f_slot[3:0]] <= f_coef;
      if (cmd.op == tsrs_pkg::OP_COEF_RD)
         coef_rd_ff <= cmd.pass ? proj_mem[coef_addr] : view_mem[coef_addr];
   end

   always_ff @(posedge clock) begin
      if (vtx_we) begin
         vx_mem[f_slot[AW-1:0]] <= f_vx;
         vy_mem[f_slot[AW-1:0]] <= f_vy;
      end
      if (cmd.op == tsrs_pkg::OP_VTX_RD) begin
         vx_rd_ff <= vx_mem[cmd.vtx_addr];
         vy_rd_ff <= vy_mem[cmd.vtx_addr];
      end
   end

   // Working registers
   logic signed [31:0]   px_ff, py_ff, pz_ff;
   logic                 cand_ff;
   logic signed [63:0]   prod_ff;
   logic signed [CW-1:0] acc_ff;
   logic signed [31:0]   viewed_ff [4];
   logic signed [CW-1:0] clip_ff [4];
   logic                 vis_ff;
   logic        [DW-1:0] rem_ff;
   logic        [QW-1:0] quo_ff;
   logic        [48:0]   scaled_ff;
   logic signed [31:0]   sx_ff, sy_ff;
   logic signed [31:0]   ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [32:0]   dbx_ff, dby_ff, dpx_ff, dpy_ff;
   logic signed [65:0]   p1_ff, p2_ff;
   logic                 inside_ff;

   // Multiply-accumulate operand and floored term
   logic signed [31:0]   mac_op;
   logic signed [47:0]   term;
   logic signed [CW-1:0] acc_base, acc_new;
   logic signed [31:0]   acc_sat;

   always_comb begin
      if (cmd.pass) begin
         mac_op = viewed_ff[cmd.col];
      end else begin
         case (cmd.col)
            2'd0:    mac_op = px_ff;
            2'd1:    mac_op = py_ff;
            2'd2:    mac_op = pz_ff;
            default: mac_op = 32'sh0001_0000;
         endcase
      end
   end

   assign term     = prod_ff[63:16];
   assign acc_base = (cmd.col == 2'd0) ? '0 : acc_ff;
   assign acc_new  = acc_base + CW'(term);

   always_comb begin
      if (acc_new > CW'(64'sd2147483647))       acc_sat = 32'sh7FFF_FFFF;
      else if (acc_new < CW'(-64'sd2147483648)) acc_sat = 32'sh8000_0000;
      else                                      acc_sat = acc_new[31:0];
   end

   // Clip volume test
   logic signed [CW:0] w_e, nw_e, x_e, y_e, z_e;
   logic               vis_c;

   assign w_e  = (CW+1)'(clip_ff[3]);
   assign nw_e = -w_e;
   assign x_e  = (CW+1)'(clip_ff[0]);
   assign y_e  = (CW+1)'(clip_ff[1]);
   assign z_e  = (CW+1)'(clip_ff[2]);
   assign vis_c = (w_e > 0) && x_e >= nw_e && x_e <= w_e && y_e >= nw_e && y_e <= w_e &&
                  z_e >= nw_e && z_e <= w_e;

   // Divider operands: numerator over 2w
   logic signed [CW:0] num_s;
   logic [DW-1:0]      div_num, div_den;
   logic [DW:0]        rem_sh, den_e;
   logic               step_ge;
   logic [32:0]        scaled_hi;
   logic [31:0]        sat_val;

   assign num_s   = cmd.axis ? (w_e - y_e) : (x_e + w_e);
   assign div_num = {1'b0, num_s};
   assign div_den = {1'b0, clip_ff[3], 1'b0};
   assign rem_sh  = {rem_ff, 1'b0};
   assign den_e   = {1'b0, div_den};
   assign step_ge = rem_sh >= den_e;
   assign scaled_hi = scaled_ff[48:16];
   assign sat_val = (scaled_hi[32] | scaled_hi[31]) ? 32'h7FFF_FFFF : scaled_hi[31:0];

   // Edge decision
   logic on_edge_c, cross_c, toggle_c;
   logic signed [31:0] minx, maxx, miny, maxy;

   assign minx = (ax_ff < bx_ff) ? ax_ff : bx_ff;
   assign maxx = (ax_ff > bx_ff) ? ax_ff : bx_ff;
   assign miny = (ay_ff < by_ff) ? ay_ff : by_ff;
   assign maxy = (ay_ff > by_ff) ? ay_ff : by_ff;
   assign on_edge_c = (p1_ff == p2_ff) && sx_ff >= minx && sx_ff <= maxx &&
                      sy_ff >= miny && sy_ff <= maxy;
   assign cross_c   = (ay_ff > sy_ff) != (by_ff > sy_ff);
   assign toggle_c  = (by_ff > ay_ff) ? (p2_ff < p1_ff) : (p2_ff > p1_ff);

   // Step the datapath by command
   always_ff @(posedge clock) begin
      case (cmd.op)
         tsrs_pkg::OP_START: begin
            px_ff     <= f_px;
            py_ff     <= f_py;
            pz_ff     <= f_pz;
            cand_ff   <= f_cand;
            sx_ff     <= '0;
            sy_ff     <= '0;
            vis_ff    <= 1'b0;
            inside_ff <= 1'b0;
         end
         tsrs_pkg::OP_MUL: prod_ff <= coef_rd_ff * mac_op;
         tsrs_pkg::OP_ACC: begin
            acc_ff <= acc_new;
            if (cmd.col == 2'd3) begin
               if (cmd.pass) clip_ff[cmd.row]   <= acc_new;
               else          viewed_ff[cmd.row] <= acc_sat;
            end
         end
         tsrs_pkg::OP_CLIP: vis_ff <= vis_c;
         tsrs_pkg::OP_DIV_INIT: begin
            if (div_num >= div_den) begin
               rem_ff <= div_num - div_den;
               quo_ff <= QW'(1);
            end else begin
               rem_ff <= div_num;
               quo_ff <= '0;
            end
         end
         tsrs_pkg::OP_DIV_STEP: begin
            rem_ff <= step_ge ? DW'(rem_sh - den_e) : rem_sh[DW-1:0];
            quo_ff <= {quo_ff[QW-2:0], step_ge};
         end
         tsrs_pkg::OP_SCALE:
            scaled_ff <= 49'(quo_ff) * 49'(cmd.axis ? height_ff : width_ff);
         tsrs_pkg::OP_SAT: begin
            if (cmd.axis) sy_ff <= sat_val;
            else          sx_ff <= sat_val;
         end
         tsrs_pkg::OP_VTX_LATCH: begin
            ax_ff <= vx_rd_ff;
            ay_ff <= vy_rd_ff;
         end
         tsrs_pkg::OP_EDGE_DIFF: begin
            bx_ff  <= vx_rd_ff;
            by_ff  <= vy_rd_ff;
            dbx_ff <= 33'(vx_rd_ff) - 33'(ax_ff);
            dby_ff <= 33'(vy_rd_ff) - 33'(ay_ff);
            dpx_ff <= 33'(sx_ff) - 33'(ax_ff);
            dpy_ff <= 33'(sy_ff) - 33'(ay_ff);
         end
         tsrs_pkg::OP_EDGE_MUL: begin
            p1_ff <= dbx_ff * dpy_ff;
            p2_ff <= dby_ff * dpx_ff;
         end
         tsrs_pkg::OP_EDGE_DEC: begin
            if (on_edge_c)                inside_ff <= 1'b1;
            else if (cross_c && toggle_c) inside_ff <= ~inside_ff;
            ax_ff <= bx_ff;
            ay_ff <= by_ff;
         end
         default: ;
      endcase
   end

   // Response register
   logic        rsp_valid_ff;
   logic [71:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == tsrs_pkg::OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == tsrs_pkg::OP_EMIT)
         rsp_data_ff <= {6'b0, sy_ff, sx_ff, vis_ff, cand_ff & vis_ff & inside_ff};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status to the controller
   logic [5:0] n_eff;

   assign n_eff = (count_ff > 6'(tsrs_pkg::MAX_VERTICES)) ?
                  6'(tsrs_pkg::MAX_VERTICES) : count_ff;

   always_comb begin
      status          = '0;
      status.vis      = vis_c;
      status.on_edge  = on_edge_c;
      status.n_zero   = (count_ff == 6'd0);
      status.n_last   = AW'(n_eff - 6'd1);
      status.rsp_free = ~rsp_valid_ff | rsp_tready;
   end

endmodule
`default_nettype wire

FILE: rtl/core/texel_screen_region_select_unit.sv
// Load requests are accepted back to back while the unit is idle.
// A test request runs the shared multiply-accumulate for both matrices, then the serial
// divider once per screen axis, then reads, differences, multiplies and decides per polygon
// edge; a point outside the clip volume answers straight after the clip test.
// One request is worked at a time; a test whose response finds the previous one still waiting
// holds in its last cycle, with the input stalled, until that response is taken.
// Reset is synchronous and clears the sequencer, response valid and the configuration
// registers; coefficient and vertex stores hold nothing defined until written.
`default_nettype none
module texel_screen_region_select_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // action[1:0], matrix_select[2]
   input  wire logic [2:0]   req_tuser,
   // slot_index[4:0], coefficient_value[36:5], vertex_x[68:37], vertex_y[100:69],
   // position_x[132:101], position_y[164:133], position_z[196:165], is_candidate[197]
   input  wire logic [199:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // selected[0], in_view[1], screen_x[33:2], screen_y[65:34]
   output logic [71:0]       rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   tsrs_pkg::cmd_type    cmd;
   tsrs_pkg::status_type status;

   tsrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser[1:0]),
      .status     (status),
      .cmd        (cmd)
   );

   tsrs_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   assign req_tready = cmd.req_ready;
   assign csr_ready  = 1'b1;

endmodule
`default_nettype wire

FILE: rtl/core/tsrs_chk.sv
`default_nettype none
`include "texel_screen_region_select_unit_assert.svh"
module tsrs_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata
);

   // Hold a stalled response
   `TSRS_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `TSRS_ASSERT_NXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   // Out of view: zero coordinates, never selected
   `TSRS_ASSERT_IMP(a_off_view, rsp_tvalid && !rsp_tdata[1], rsp_tdata[65:0] == 66'd0)
   // In view: both pixel coordinates are non-negative
   `TSRS_ASSERT_IMP(a_on_view, rsp_tvalid && rsp_tdata[1], !rsp_tdata[33] && !rsp_tdata[65])

endmodule

bind texel_screen_region_select_unit tsrs_chk u_chk (.*);
`default_nettype wire
